// ===== rtl/core/erm_pkg.sv =====
`default_nettype none

package erm_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int LETTER_W      = 5;
  localparam int MODEL_W       = 4;
  localparam int MODEL_COUNT   = 10;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [MODEL_W-1:0]  model_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_MAP  = 1'b1
  } action_t;

  typedef struct packed {
    logic    we;
    letter_t idx;
    letter_t data;
  } refl_wr_t;

  // One ASCII letter per position, position 0 in the top byte.
  localparam logic [8*ALPHABET_SIZE-1:0] WIRINGS [MODEL_COUNT] = '{
    "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
    "AJDKSIRUXBLHWTMCQGZNPYFVOE",
    "BDFHJLCPRTXVZNYEIWGAKMUSQO",
    "ESOVPZJAYQUIRHXLNFTGKDCMWB",
    "VZBRGITYUPSDNHLXAWMJQOFECK",
    "JPGVOUMFYQBENHZRDKASXLICTW",
    "NZJHGRCXMYSWBOUFAIVLPEKQDT",
    "FKQHTLXOCBJSPDZRAMEWNIUYGV",
    "LEYJVCNIXWPBQMDRTAKZGFUHOS",
    "FSOKANUERHMBTIYCWLQPZXVGJD"
  };

  localparam logic [ALPHABET_SIZE-1:0] NOTCH_MASKS [MODEL_COUNT] = '{
    26'd1 << 16,
    26'd1 << 4,
    26'd1 << 21,
    26'd1 << 9,
    26'd1 << 25,
    (26'd1 << 25) | (26'd1 << 12),
    (26'd1 << 25) | (26'd1 << 12),
    (26'd1 << 25) | (26'd1 << 12),
    26'd0,
    26'd0
  };

  function automatic letter_t mod_reduce(letter_t v);
    return (v >= LETTER_W'(ALPHABET_SIZE)) ? v - LETTER_W'(ALPHABET_SIZE) : v;
  endfunction

  function automatic letter_t add_mod(letter_t a, letter_t b);
    logic [LETTER_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (LETTER_W+1)'(ALPHABET_SIZE)) begin
      s = s - (LETTER_W+1)'(ALPHABET_SIZE);
    end
    return s[LETTER_W-1:0];
  endfunction

  function automatic letter_t sub_mod(letter_t a, letter_t b);
    return (a >= b) ? a - b : a + LETTER_W'(ALPHABET_SIZE) - b;
  endfunction

  function automatic letter_t wire_fwd(model_t model, letter_t k);
    logic [7:0] ch;
    if (model >= MODEL_W'(MODEL_COUNT)) begin
      return k;
    end
    ch = WIRINGS[model][8*(ALPHABET_SIZE-1-int'(k)) +: 8];
    return LETTER_W'(ch - 8'h41);
  endfunction

  function automatic letter_t wire_inv(model_t model, letter_t v);
    letter_t res;
    res = '0;
    if (model >= MODEL_W'(MODEL_COUNT)) begin
      return v;
    end
    for (int k = 0; k < ALPHABET_SIZE; k++) begin
      if (wire_fwd(model, LETTER_W'(k)) == v) begin
        res = res | LETTER_W'(k);
      end
    end
    return res;
  endfunction

  function automatic logic notch_hit(model_t model, letter_t pos);
    if (model >= MODEL_W'(MODEL_COUNT)) begin
      return 1'b0;
    end
    return NOTCH_MASKS[model][pos];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/enigma_rotor_reflector_map_core.sv =====
`default_nettype none

// Letter path through one rotor, a reflector and back through the rotor.
//
// Input: a transaction is taken at a rising edge with start high and busy
// low. busy never rises, so one transaction can be taken every cycle.
// in_action = load writes reflector entry in_letter with in_target and
// gives no result; in_action = map sends in_letter through the rotor at
// offset in_rotor_position and back.
// Output: each map result is on out_mapped_letter / out_at_turnover for one
// cycle with out_valid high, registered in the output stage. Results come in
// input order. The receiver cannot stall; it must take every strobe.
// The path has three register stages (input, rotor forward, reflector and
// rotor return); no stage ever stalls, so throughput is one transaction per
// cycle.
// Config: cfg_data selects the rotor model, written when cfg_valid is high
// (cfg_ready is always high); write it only while no map is in flight.
// Reset (rst_n low, synchronous) empties the pipeline and sets the model to
// rotor I. Reflector entries stay undefined until loaded.

module enigma_rotor_reflector_map_core
  import erm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire logic    in_action,
  input  wire letter_t in_letter,
  input  wire letter_t in_target,
  input  wire letter_t in_rotor_position,
  output logic         out_valid,
  output letter_t      out_mapped_letter,
  output logic         out_at_turnover,
  input  wire logic    cfg_valid,
  output logic         cfg_ready,
  input  wire model_t  cfg_data
);

  model_t  rotor_model_r;

  logic    s1_valid_r;
  action_t s1_action_r;
  letter_t s1_letter_r;
  letter_t s1_target_r;
  letter_t s1_pos_r;

  logic    s2_valid_r;
  action_t s2_action_r;
  letter_t s2_idx_r;
  letter_t s2_target_r;
  letter_t s2_pos_r;
  logic    s2_turn_r;

  logic    out_valid_r;
  letter_t out_letter_r;
  logic    out_turn_r;

  letter_t  s1_x;
  letter_t  s1_p;
  letter_t  s2_idx_nxt;
  logic     s2_turn_nxt;
  letter_t  refl_data;
  letter_t  s2_c;
  letter_t  out_letter_nxt;
  refl_wr_t refl_wr;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotor_model_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      rotor_model_r <= cfg_data;
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_action_r <= action_t'(in_action);
    s1_letter_r <= in_letter;
    s1_target_r <= in_target;
    s1_pos_r    <= in_rotor_position;
  end

  // forward through the rotor
  always_comb begin
    s1_x        = mod_reduce(s1_letter_r);
    s1_p        = mod_reduce(s1_pos_r);
    s2_turn_nxt = notch_hit(rotor_model_r, s1_p);
    if (s1_action_r == ACT_MAP) begin
      s2_idx_nxt = sub_mod(wire_fwd(rotor_model_r, add_mod(s1_x, s1_p)), s1_p);
    end else begin
      s2_idx_nxt = s1_letter_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_action_r <= s1_action_r;
    s2_idx_r    <= s2_idx_nxt;
    s2_target_r <= s1_target_r;
    s2_pos_r    <= s1_p;
    s2_turn_r   <= s2_turn_nxt;
  end

  // loads and reads share this stage, so transactions stay in order
  assign refl_wr.we   = s2_valid_r && (s2_action_r == ACT_LOAD) &&
                        (s2_idx_r < LETTER_W'(ALPHABET_SIZE));
  assign refl_wr.idx  = s2_idx_r;
  assign refl_wr.data = s2_target_r;

  erm_reflector u_reflector (
    .clk     (clk),
    .wr      (refl_wr),
    .rd_idx  (s2_idx_r),
    .rd_data (refl_data)
  );

  always_comb begin
    s2_c           = add_mod(refl_data, s2_pos_r);
    out_letter_nxt = sub_mod(wire_inv(rotor_model_r, s2_c), s2_pos_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid_r && (s2_action_r == ACT_MAP);
    end
  end

  always_ff @(posedge clk) begin
    out_letter_r <= out_letter_nxt;
    out_turn_r   <= s2_turn_r;
  end

  assign out_valid         = out_valid_r;
  assign out_mapped_letter = out_letter_r;
  assign out_at_turnover   = out_turn_r;

`ifndef SYNTHESIS
  a_map_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action) |-> ##3 out_valid)
    else $error("map transaction lost");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_action) |-> ##3 !out_valid)
    else $error("load transaction produced a result");

  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mapped_letter < LETTER_W'(ALPHABET_SIZE)))
    else $error("mapped letter out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/erm_reflector.sv =====
`default_nettype none

module erm_reflector
  import erm_pkg::*;
(
  input  wire logic     clk,
  input  wire refl_wr_t wr,
  input  wire letter_t  rd_idx,
  output letter_t       rd_data
);

  letter_t table_r [ALPHABET_SIZE];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      table_r[wr.idx] <= wr.data;
    end
  end

  // stored raw, reduced on the way out
  assign rd_data = mod_reduce(table_r[rd_idx]);

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import erm_pkg::*;

  typedef struct packed {
    action_t act;
    letter_t letter;
    letter_t target;
    letter_t pos;
  } letter_req_t;

  typedef struct packed {
    letter_t mapped;
    logic    turnover;
  } path_result_t;

  string rotor_wiring [0:9] = '{
    "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
    "AJDKSIRUXBLHWTMCQGZNPYFVOE",
    "BDFHJLCPRTXVZNYEIWGAKMUSQO",
    "ESOVPZJAYQUIRHXLNFTGKDCMWB",
    "VZBRGITYUPSDNHLXAWMJQOFECK",
    "JPGVOUMFYQBENHZRDKASXLICTW",
    "NZJHGRCXMYSWBOUFAIVLPEKQDT",
    "FKQHTLXOCBJSPDZRAMEWNIUYGV",
    "LEYJVCNIXWPBQMDRTAKZGFUHOS",
    "FSOKANUERHMBTIYCWLQPZXVGJD"
  };
  string notch_letters [0:9] = '{"Q", "E", "V", "J", "Z", "ZM", "ZM", "ZM", "", ""};

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  logic    in_action = 1'b0;
  letter_t in_letter = '0;
  letter_t in_target = '0;
  letter_t in_rotor_position = '0;
  logic    out_valid;
  letter_t out_mapped_letter;
  logic    out_at_turnover;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  model_t  cfg_data = '0;

  letter_req_t  pending_reqs [$];
  path_result_t expected_paths [$];
  logic [4:0]   refl_entry [26];
  model_t       rotor_model_q = '0;
  bit           gen_written [26];
  int           errors = 0;
  int           cycle_cnt = 0;

  enigma_rotor_reflector_map_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_letter         (in_letter),
    .in_target         (in_target),
    .in_rotor_position (in_rotor_position),
    .out_valid         (out_valid),
    .out_mapped_letter (out_mapped_letter),
    .out_at_turnover   (out_at_turnover),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int rotor_fwd(int m, int k);
    if (m >= 10) begin
      return k;
    end
    return int'(rotor_wiring[m][k]) - 65;
  endfunction

  function automatic int rotor_back(int m, int v);
    if (m >= 10) begin
      return v;
    end
    for (int k = 0; k < 26; k++) begin
      if (rotor_fwd(m, k) == v) begin
        return k;
      end
    end
    return 0;
  endfunction

  function automatic bit turnover_hit(int m, int p);
    if (m >= 10) begin
      return 1'b0;
    end
    for (int i = 0; i < notch_letters[m].len(); i++) begin
      if (int'(notch_letters[m][i]) - 65 == p) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // reflector entry that a map transaction reads
  function automatic int refl_index(int m, int letter, int pos);
    int x;
    int p;
    x = letter % 26;
    p = pos % 26;
    return (rotor_fwd(m, (x + p) % 26) + 26 - p) % 26;
  endfunction

  function automatic path_result_t trace_letter_path(int m, int letter, int pos);
    path_result_t r;
    int p;
    int c;
    p = pos % 26;
    c = (int'(refl_entry[refl_index(m, letter, pos)]) + p) % 26;
    r.mapped = letter_t'((rotor_back(m, c) + 26 - p) % 26);
    r.turnover = turnover_hit(m, p);
    return r;
  endfunction

  task automatic push_load(int letter, int target);
    letter_req_t r;
    r.act = ACT_LOAD;
    r.letter = letter_t'(letter);
    r.target = letter_t'(target);
    r.pos = letter_t'($urandom_range(0, 31));
    pending_reqs.push_back(r);
    if (letter < 26) begin
      gen_written[letter] = 1'b1;
    end
  endtask

  // a map whose reflector entry was never written gets a load first
  task automatic push_map(int m, int letter, int pos);
    letter_req_t r;
    int e;
    e = refl_index(m, letter, pos);
    if (!gen_written[e]) begin
      push_load(e, $urandom_range(0, 31));
    end
    r.act = ACT_MAP;
    r.letter = letter_t'(letter);
    r.target = letter_t'($urandom_range(0, 31));
    r.pos = letter_t'(pos);
    pending_reqs.push_back(r);
  endtask

  task automatic fill_random(int m, int n);
    int cnt;
    int letter;
    int pos;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 99) < 30) begin
        letter = $urandom_range(0, 31);
        push_load(letter, $urandom_range(0, 31));
        if (letter < 26) begin
          cnt++;
        end
      end else begin
        letter = $urandom_range(0, 31);
        pos = $urandom_range(0, 31);
        if ($urandom_range(0, 4) == 0) begin
          pos = ($urandom_range(0, 1) == 0) ? 12 : 25;
        end
        push_map(m, letter, pos);
        cnt++;
      end
    end
  endtask

  task automatic drain();
    int w;
    while (pending_reqs.size() != 0 || start) begin
      @(negedge clk);
    end
    w = 0;
    while (w < 40 && expected_paths.size() != 0) begin
      @(negedge clk);
      w++;
    end
    if (expected_paths.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_paths.size());
      errors++;
      expected_paths.delete();
    end
    repeat (6) @(negedge clk);
  endtask

  task automatic set_model(model_t m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rotor_model_q = m;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_proc
    letter_req_t nxt;
    path_result_t res;
    bit calm;
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (action_t'(in_action) == ACT_LOAD) begin
          if (in_letter < 26) begin
            refl_entry[in_letter] = in_target;
          end
        end else begin
          res = trace_letter_path(int'(rotor_model_q), int'(in_letter),
                                  int'(in_rotor_position));
          expected_paths.push_back(res);
        end
      end
      if (!start || !busy) begin
        calm = (cycle_cnt >= 200 && cycle_cnt < 500);
        if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 14)) begin
          nxt = pending_reqs.pop_front();
          start <= 1'b1;
          in_action <= nxt.act;
          in_letter <= nxt.letter;
          in_target <= nxt.target;
          in_rotor_position <= nxt.pos;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_proc
    path_result_t want;
    if (rst_n && out_valid) begin
      if (expected_paths.size() == 0) begin
        $display("%0t: unexpected result letter %0d turnover %0b", $time,
                 out_mapped_letter, out_at_turnover);
        errors++;
      end else begin
        want = expected_paths.pop_front();
        if (out_mapped_letter !== want.mapped) begin
          $display("%0t: mapped_letter expected %0d actual %0d", $time,
                   want.mapped, out_mapped_letter);
          errors++;
        end
        if (out_at_turnover !== want.turnover) begin
          $display("%0t: at_turnover expected %0b actual %0b", $time,
                   want.turnover, out_at_turnover);
          errors++;
        end
      end
    end
  end

  initial begin : stim_proc
    model_t phase_models [16];
    phase_models = '{4'd9, 4'd15, 4'd0, 4'd3, 4'd12, 4'd7, 4'd1, 4'd8,
                     4'd4, 4'd2, 4'd5, 4'd6, 4'd11, 4'd13, 4'd14, 4'd10};
    for (int i = 0; i < 26; i++) begin
      gen_written[i] = 1'b0;
      refl_entry[i] = '0;
    end

    // model I straight out of reset
    push_load(31, 3);
    push_load(0, 31);
    push_load(25, 0);
    push_load(13, 26);
    push_map(0, 20, 0);
    push_map(0, 9, 0);
    push_map(0, 10, 0);
    push_map(0, 0, 0);
    push_map(0, 25, 25);
    push_map(0, 31, 31);
    push_map(0, 26, 16);
    push_map(0, 7, 16);
    push_map(0, 3, 30);
    push_load(refl_index(0, 3, 9), 17);
    push_map(0, 3, 9);
    push_map(0, 12, 15);
    push_map(0, 19, 28);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    drain();

    foreach (phase_models[i]) begin
      set_model(phase_models[i]);
      fill_random(int'(phase_models[i]), 65);
      drain();
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
